@@ hdl/dna_consensus_column_vote_unit_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef DNA_CONSENSUS_COLUMN_VOTE_UNIT_DEFINES_SVH
`define DNA_CONSENSUS_COLUMN_VOTE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DCV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dcv_pkg.sv @@
package dcv_pkg;

    localparam logic [7:0] SYM_A = 8'h41;
    localparam logic [7:0] SYM_C = 8'h43;
    localparam logic [7:0] SYM_G = 8'h47;
    localparam logic [7:0] SYM_T = 8'h54;

    localparam logic [1:0] BASE_A = 2'd0;

    localparam int NUM_SEQ_W = 7;
    localparam int SEQ_LEN_W = 11;
    localparam int COLUMN_W  = 10;
    localparam int DIST_W    = 17;
    localparam int SYMBOL_W  = 8;
    localparam int BASE_W    = 2;
    localparam int NUM_BASES = 4;
    localparam int M_TDATA_W = 32;
    localparam int S_TDATA_W = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    typedef enum logic {
        REG_NUM_SEQUENCES = 1'b0,
        REG_SEQ_LENGTH    = 1'b1
    } reg_index_t;

    localparam logic [NUM_SEQ_W-1:0] NUM_SEQ_RESET = 7'd1;
    localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 11'd1;

endpackage

@@ hdl/dcv_ram.sv @@
module dcv_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/dna_consensus_column_vote_unit.sv @@
// Path: an accepted symbol is registered in stage s1, where its column count is updated and,
// on the last row, voted; s1 then hands the vote to the output register that drives m_tvalid.
// Throughput: one symbol per cycle, held while a vote waits on m_tready; set by the count
// memory's read-modify-write per column, whose single-column read-after-write hazard is forwarded.
// Reset: synchronous active-low aresetn clears the counters, the distance sum and the
// pipeline; the count memory needs no clearing pass since the first row ignores stored counts.
`include "dna_consensus_column_vote_unit_defines.svh"

module dna_consensus_column_vote_unit #(
    parameter int MAX_SEQS = 64,
    parameter int MAX_LEN  = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [7:0] symbol
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcv_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: [9:0] column, [11:10] base_code, [28:12] total_distance, [31:29] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dcv_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dcv_pkg::APB_AW-1:0]     paddr,
    input  logic [dcv_pkg::APB_DW-1:0]     pwdata,
    output logic [dcv_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int CNT_W  = $clog2(MAX_SEQS + 1);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int WORD_W = dcv_pkg::NUM_BASES * CNT_W;

    logic [dcv_pkg::NUM_SEQ_W-1:0] num_seq_reg, num_seq_next;
    logic [dcv_pkg::SEQ_LEN_W-1:0] seq_len_reg, seq_len_next;
    logic                          cfg_write;
    logic [CNT_W-1:0]              m_eff;
    logic [LEN_W-1:0]              n_eff;

    logic [CNT_W-1:0]  row_reg, row_next;
    logic [AW-1:0]     col_reg, col_next;
    logic              row_last, col_last;

    logic              s1_valid_reg, s1_valid_next;
    logic [AW-1:0]     s1_col_reg;
    logic              s1_row0_reg, s1_emit_reg, s1_lastcol_reg;
    logic [dcv_pkg::SYMBOL_W-1:0] s1_sym_reg;

    logic              lw_valid_reg, lw_valid_next;
    logic [AW-1:0]     lw_col_reg;
    logic [WORD_W-1:0] lw_data_reg;

    logic [dcv_pkg::DIST_W-1:0] dist_reg, dist_next, dist_sum;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [dcv_pkg::COLUMN_W-1:0] m_col_reg;
    logic [dcv_pkg::BASE_W-1:0]   m_base_reg;
    logic [dcv_pkg::DIST_W-1:0]   m_dist_reg;
    logic              m_last_reg;

    logic              out_free, advance, accept, s1_done;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata, old_word, new_word;
    logic [CNT_W-1:0]  cnt [dcv_pkg::NUM_BASES];
    logic [CNT_W-1:0]  best;
    logic [dcv_pkg::BASE_W-1:0] code;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        num_seq_next = num_seq_reg;
        seq_len_next = seq_len_reg;
        if (cfg_write) begin
            unique case (dcv_pkg::reg_index_t'(paddr[2]))
                dcv_pkg::REG_NUM_SEQUENCES: num_seq_next = pwdata[dcv_pkg::NUM_SEQ_W-1:0];
                dcv_pkg::REG_SEQ_LENGTH:    seq_len_next = pwdata[dcv_pkg::SEQ_LEN_W-1:0];
                default:                    num_seq_next = num_seq_reg;
            endcase
        end
    end

    always_comb begin
        unique case (dcv_pkg::reg_index_t'(paddr[2]))
            dcv_pkg::REG_NUM_SEQUENCES:
                prdata = {{(dcv_pkg::APB_DW-dcv_pkg::NUM_SEQ_W){1'b0}}, num_seq_reg};
            dcv_pkg::REG_SEQ_LENGTH:
                prdata = {{(dcv_pkg::APB_DW-dcv_pkg::SEQ_LEN_W){1'b0}}, seq_len_reg};
            default:
                prdata = '0;
        endcase
    end

    always_comb begin
        if (num_seq_reg == '0) begin
            m_eff = CNT_W'(1);
        end else if (int'(num_seq_reg) > MAX_SEQS) begin
            m_eff = CNT_W'(MAX_SEQS);
        end else begin
            m_eff = CNT_W'(num_seq_reg);
        end
        if (seq_len_reg == '0) begin
            n_eff = LEN_W'(1);
        end else if (int'(seq_len_reg) > MAX_LEN) begin
            n_eff = LEN_W'(MAX_LEN);
        end else begin
            n_eff = LEN_W'(seq_len_reg);
        end
    end

    // Handshake.
    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = !s1_valid_reg || !s1_emit_reg || out_free;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign s1_done  = s1_valid_reg && advance;

    // Row and column position of the next symbol.
    assign row_last = (row_reg == m_eff - CNT_W'(1));
    assign col_last = (LEN_W'(col_reg) == n_eff - LEN_W'(1));

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write) begin
            row_next = '0;
            col_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    // Count memory.
    dcv_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_LEN)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (new_word),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign ram_we = s1_valid_reg && !s1_emit_reg;

    always_comb begin
        if (s1_row0_reg) begin
            old_word = '0;
        end else if (lw_valid_reg && (lw_col_reg == s1_col_reg)) begin
            old_word = lw_data_reg;
        end else begin
            old_word = ram_rdata;
        end
    end

    always_comb begin
        for (int k = 0; k < dcv_pkg::NUM_BASES; k++) begin
            cnt[k] = old_word[k*CNT_W +: CNT_W];
        end
        case (s1_sym_reg)
            dcv_pkg::SYM_A: cnt[0] = cnt[0] + CNT_W'(1);
            dcv_pkg::SYM_C: cnt[1] = cnt[1] + CNT_W'(1);
            dcv_pkg::SYM_G: cnt[2] = cnt[2] + CNT_W'(1);
            dcv_pkg::SYM_T: cnt[3] = cnt[3] + CNT_W'(1);
            default:        cnt[0] = cnt[0];
        endcase
        for (int k = 0; k < dcv_pkg::NUM_BASES; k++) begin
            new_word[k*CNT_W +: CNT_W] = cnt[k];
        end
    end

    always_comb begin
        best = cnt[0];
        code = dcv_pkg::BASE_A;
        for (int k = 1; k < dcv_pkg::NUM_BASES; k++) begin
            if (cnt[k] > best) begin
                best = cnt[k];
                code = dcv_pkg::BASE_W'(k);
            end
        end
    end

    assign dist_sum = dist_reg + dcv_pkg::DIST_W'(m_eff - best);

    always_comb begin
        dist_next = dist_reg;
        if (cfg_write) begin
            dist_next = '0;
        end else if (s1_done && s1_emit_reg) begin
            dist_next = s1_lastcol_reg ? '0 : dist_sum;
        end
    end

    always_comb begin
        lw_valid_next = lw_valid_reg;
        if (cfg_write) begin
            lw_valid_next = 1'b0;
        end else if (s1_done) begin
            lw_valid_next = !s1_emit_reg;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s1_done && s1_emit_reg) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_seq_reg  <= dcv_pkg::NUM_SEQ_RESET;
            seq_len_reg  <= dcv_pkg::SEQ_LEN_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            dist_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            num_seq_reg  <= num_seq_next;
            seq_len_reg  <= seq_len_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
            lw_valid_reg <= lw_valid_next;
            dist_reg     <= dist_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg     <= col_reg;
            s1_row0_reg    <= (row_reg == '0);
            s1_emit_reg    <= row_last;
            s1_lastcol_reg <= col_last;
            s1_sym_reg     <= s_tdata[dcv_pkg::SYMBOL_W-1:0];
        end
        if (s1_done) begin
            lw_col_reg  <= s1_col_reg;
            lw_data_reg <= new_word;
        end
        if (s1_done && s1_emit_reg) begin
            m_col_reg  <= dcv_pkg::COLUMN_W'(s1_col_reg);
            m_base_reg <= code;
            m_dist_reg <= dist_sum;
            m_last_reg <= s1_lastcol_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(dcv_pkg::M_TDATA_W - dcv_pkg::DIST_W - dcv_pkg::BASE_W
                         - dcv_pkg::COLUMN_W){1'b0}}, m_dist_reg, m_base_reg, m_col_reg};

    `DCV_ASSERT_NEXT(a_last_row_emits, aclk, aresetn, accept && row_last,
        s1_valid_reg && s1_emit_reg, "symbol of the last row did not reach the vote")
    `DCV_ASSERT_NOW(a_vote_no_write, aclk, aresetn, s1_valid_reg && s1_emit_reg,
        !ram_we, "voted column was written back to the count memory")
    `DCV_ASSERT_NEXT(a_set_end_clears_sum, aclk, aresetn,
        s1_done && s1_emit_reg && s1_lastcol_reg,
        dist_reg == '0, "set end did not clear the distance sum")
    `DCV_ASSERT_NOW(a_row_in_range, aclk, aresetn, s1_valid_reg || !s1_valid_reg,
        row_reg < m_eff, "row index beyond the number of sequences")

endmodule

@@ dv/dna_consensus_column_vote_unit_test.sv @@
`timescale 1ns / 100ps

module dna_consensus_column_vote_unit_test;

    localparam int MAX_SEQS     = 64;
    localparam int MAX_LEN      = 1024;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PIPE_SETTLE  = 6;
    localparam int RANDOM_ITEMS = 750;
    localparam int PRINT_CAP    = 100;

    typedef enum logic [1:0] {
        CODE_A = 2'd0,
        CODE_C = 2'd1,
        CODE_G = 2'd2,
        CODE_T = 2'd3
    } base_code_t;

    typedef struct packed {
        logic [dcv_pkg::COLUMN_W-1:0] column;
        logic [dcv_pkg::BASE_W-1:0]   base_code;
        logic [dcv_pkg::DIST_W-1:0]   total_distance;
        logic                         last_column;
    } vote_t;

    class consensus_scoreboard;
        logic [dcv_pkg::NUM_SEQ_W-1:0] num_seqs_reg;
        logic [dcv_pkg::SEQ_LEN_W-1:0] seq_len_reg;
        bit [6:0]                      tally [MAX_LEN][dcv_pkg::NUM_BASES];
        int unsigned                   row;
        int unsigned                   col;
        logic [dcv_pkg::DIST_W-1:0]    distance_sum;
        vote_t                         expected_votes [$];
        int                            errors;
        int                            printed;

        function void restart();
            foreach (tally[i, j]) tally[i][j] = '0;
            row = 0;
            col = 0;
            distance_sum = '0;
        endfunction

        function void init();
            num_seqs_reg = dcv_pkg::NUM_SEQ_RESET;
            seq_len_reg = dcv_pkg::SEQ_LEN_RESET;
            errors = 0;
            printed = 0;
            expected_votes.delete();
            restart();
        endfunction

        function int unsigned active_seqs();
            if (num_seqs_reg == 0) return 1;
            if (num_seqs_reg > MAX_SEQS) return MAX_SEQS;
            return num_seqs_reg;
        endfunction

        function int unsigned active_len();
            if (seq_len_reg == 0) return 1;
            if (seq_len_reg > MAX_LEN) return MAX_LEN;
            return seq_len_reg;
        endfunction

        function void write_reg(dcv_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                dcv_pkg::REG_NUM_SEQUENCES: num_seqs_reg = value[dcv_pkg::NUM_SEQ_W-1:0];
                dcv_pkg::REG_SEQ_LENGTH:    seq_len_reg = value[dcv_pkg::SEQ_LEN_W-1:0];
                default: ;
            endcase
            restart();
        endfunction

        function logic [31:0] reg_value(dcv_pkg::reg_index_t idx);
            if (idx == dcv_pkg::REG_NUM_SEQUENCES) return 32'(num_seqs_reg);
            return 32'(seq_len_reg);
        endfunction

        function int pending();
            return expected_votes.size();
        endfunction

        function void report(string msg);
            errors++;
            if (printed < PRINT_CAP) begin
                $display("ERROR at %0t: %s", $time, msg);
                printed++;
            end
        endfunction

        function void note_symbol(logic [7:0] sym);
            int unsigned m;
            int unsigned n;
            int unsigned best;
            int          k;
            base_code_t  code;
            vote_t       v;
            m = active_seqs();
            n = active_len();
            case (sym)
                dcv_pkg::SYM_A: tally[col][CODE_A]++;
                dcv_pkg::SYM_C: tally[col][CODE_C]++;
                dcv_pkg::SYM_G: tally[col][CODE_G]++;
                dcv_pkg::SYM_T: tally[col][CODE_T]++;
                default: ;
            endcase
            if (row == m - 1) begin
                best = tally[col][CODE_A];
                code = CODE_A;
                for (k = 1; k < dcv_pkg::NUM_BASES; k++) begin
                    if (tally[col][k] > best) begin
                        best = tally[col][k];
                        code = base_code_t'(k);
                    end
                end
                distance_sum = distance_sum + (dcv_pkg::DIST_W)'(m - best);
                v.column = col[dcv_pkg::COLUMN_W-1:0];
                v.base_code = code;
                v.total_distance = distance_sum;
                v.last_column = (col == n - 1);
                expected_votes.push_back(v);
                for (k = 0; k < dcv_pkg::NUM_BASES; k++) tally[col][k] = '0;
            end
            if (col == n - 1) begin
                col = 0;
                if (row == m - 1) begin
                    row = 0;
                    distance_sum = '0;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
        endfunction

        function void check_vote(logic [dcv_pkg::M_TDATA_W-1:0] tdata, logic tlast);
            vote_t want;
            if (expected_votes.size() == 0) begin
                report($sformatf("unexpected result transaction, tdata=%h tlast=%b",
                                 tdata, tlast));
                return;
            end
            want = expected_votes.pop_front();
            if (tdata[9:0] !== want.column)
                report($sformatf("column %0d, expected %0d", tdata[9:0], want.column));
            if (tdata[11:10] !== want.base_code)
                report($sformatf("column %0d: base_code %0d, expected %0d",
                                 want.column, tdata[11:10], want.base_code));
            if (tdata[28:12] !== want.total_distance)
                report($sformatf("column %0d: total_distance %0d, expected %0d",
                                 want.column, tdata[28:12], want.total_distance));
            if (tlast !== want.last_column)
                report($sformatf("column %0d: last_column %b, expected %b",
                                 want.column, tlast, want.last_column));
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dcv_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dcv_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tlast;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [dcv_pkg::APB_AW-1:0]     paddr = '0;
    logic [dcv_pkg::APB_DW-1:0]     pwdata = '0;
    logic [dcv_pkg::APB_DW-1:0]     prdata;
    logic                           pready;

    consensus_scoreboard sb;
    bit                  tx_steady;
    bit                  rx_steady;
    int                  stall_left;
    int                  idle_cycles;
    int unsigned         sent_count;

    dna_consensus_column_vote_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            sb.check_vote(m_tdata, m_tlast);
            stall_left = rx_steady ? 0 : $urandom_range(0, 3);
            m_tready <= (stall_left == 0);
        end else if (!m_tready) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [7:0] base_symbol(base_code_t code);
        case (code)
            CODE_A:  return dcv_pkg::SYM_A;
            CODE_C:  return dcv_pkg::SYM_C;
            CODE_G:  return dcv_pkg::SYM_G;
            default: return dcv_pkg::SYM_T;
        endcase
    endfunction

    // Mostly the column's favored base so that votes are meaningful, with
    // other bases and arbitrary bytes mixed in.
    function automatic logic [7:0] pick_symbol(base_code_t fav);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return base_symbol(fav);
        if (r < 8) return base_symbol(base_code_t'($urandom_range(0, 3)));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_symbol(input logic [7:0] sym);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sym;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_symbol(sym);
        sent_count++;
    endtask

    task automatic drain_votes();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write_en, input dcv_pkg::reg_index_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write_en;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_and_verify(input dcv_pkg::reg_index_t idx, input logic [31:0] word);
        logic [31:0] rdata;
        apb_access(1'b1, idx, word, rdata);
        sb.write_reg(idx, word);
        apb_access(1'b0, idx, $urandom, rdata);
        if (rdata !== sb.reg_value(idx))
            sb.report($sformatf("register %s reads %h, expected %h",
                                idx.name(), rdata, sb.reg_value(idx)));
    endtask

    task automatic configure(input logic [31:0] seqs_word, input logic [31:0] len_word);
        drain_votes();
        if ($urandom_range(0, 1) == 0) begin
            write_and_verify(dcv_pkg::REG_NUM_SEQUENCES, seqs_word);
            write_and_verify(dcv_pkg::REG_SEQ_LENGTH, len_word);
        end else begin
            write_and_verify(dcv_pkg::REG_SEQ_LENGTH, len_word);
            write_and_verify(dcv_pkg::REG_NUM_SEQUENCES, seqs_word);
        end
    endtask

    task automatic stream_sets(input int sets, input bit cut_short);
        int unsigned m;
        int unsigned n;
        int unsigned total;
        int unsigned i;
        base_code_t  favorite [MAX_LEN];
        m = sb.active_seqs();
        n = sb.active_len();
        for (i = 0; i < n; i++) favorite[i] = base_code_t'($urandom_range(0, 3));
        total = sets * m * n;
        if (cut_short && total > 1) total = $urandom_range(1, total - 1);
        if (sent_count < RANDOM_ITEMS && total > RANDOM_ITEMS - sent_count)
            total = RANDOM_ITEMS - sent_count;
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        for (i = 0; i < total; i++) begin
            if ($urandom_range(0, 63) == 0) drain_votes();
            send_symbol(pick_symbol(favorite[i % n]));
        end
    endtask

    function automatic logic [31:0] random_seqs_word();
        int unsigned r;
        logic [6:0]  value;
        r = $urandom_range(0, 9);
        if (r == 0) value = 7'd0;
        else if (r == 1) value = 7'($urandom_range(65, 127));
        else value = 7'($urandom_range(1, 6));
        return ($urandom & ~32'h7F) | 32'(value);
    endfunction

    function automatic logic [31:0] random_len_word();
        int unsigned r;
        logic [10:0] value;
        r = $urandom_range(0, 9);
        if (r == 0) value = 11'd0;
        else if (r == 1) value = 11'($urandom_range(17, 40));
        else value = 11'($urandom_range(1, 12));
        return ($urandom & ~32'h7FF) | 32'(value);
    endfunction

    initial begin
        logic [7:0] single_column [8];
        logic [7:0] tie_rows [15];
        single_column = '{dcv_pkg::SYM_A, dcv_pkg::SYM_C, dcv_pkg::SYM_G,
                          dcv_pkg::SYM_T, 8'h00, 8'hFF, 8'h61, 8'h80};
        // Three rows of five columns: an A/C tie, a C/G tie, a clear T,
        // a G/T tie and a column without any base.
        tie_rows = '{dcv_pkg::SYM_A, dcv_pkg::SYM_C, dcv_pkg::SYM_T,
                     dcv_pkg::SYM_G, 8'h2D,
                     dcv_pkg::SYM_C, dcv_pkg::SYM_G, dcv_pkg::SYM_G,
                     dcv_pkg::SYM_T, 8'h61,
                     8'h4E, 8'h78, dcv_pkg::SYM_T, 8'h51, 8'hFF};
        sb = new();
        sb.init();
        sent_count = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (single_column[i]) send_symbol(single_column[i]);
        configure(32'd3, 32'd5);
        foreach (tie_rows[i]) send_symbol(tie_rows[i]);

        configure(32'hFFFF_FF7F, 32'hA5A5_A001);
        stream_sets(2, 1'b0);
        configure(32'h0000_0000, 32'h0000_0000);
        stream_sets(3, 1'b0);
        configure(32'd64, 32'd3);
        stream_sets(1, 1'b0);
        configure(32'd5, 32'd7);
        stream_sets(2, 1'b1);

        while (sent_count < RANDOM_ITEMS) begin
            configure(random_seqs_word(), random_len_word());
            stream_sets($urandom_range(1, 3), $urandom_range(0, 3) == 0);
        end

        configure(32'd1, 32'h0000_07FF);

        drain_votes();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
